// ===== design/sfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sfe_pkg;

	localparam int SAMPLE_W         = 12;
	localparam int SCALED_W         = 16;
	localparam int DUTY_W           = 14;
	localparam int MODE_W           = 3;
	localparam int LEVEL_W          = 2;
	localparam int CHANNELS         = 4;
	localparam int CH_W             = 2;
	localparam int WINDOW_DEPTH_DEF = 4;
	localparam int APB_ADDR_W       = 4;
	localparam int APB_DATA_W       = 32;
	localparam int SCALE_MUL_W      = 16;
	localparam int SCALE_SHIFT      = 12;

	localparam logic [SAMPLE_W-1:0]    WINDOW_RESET = 12'd2048;
	localparam logic [SCALE_MUL_W-1:0] SCALE_MUL    = 16'd33000;

	localparam logic [DUTY_W-1:0] PWM_OFF    = 14'd0;
	localparam logic [DUTY_W-1:0] PWM_BRIGHT = 14'd500;
	localparam logic [DUTY_W-1:0] PWM_DUSK   = 14'd5000;
	localparam logic [DUTY_W-1:0] PWM_DARK   = 14'd9500;

	localparam logic [MODE_W-1:0] MODE_FIRST   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CH_B    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CH_C    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CH_D    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_LIGHT_C = 3'd5;
	localparam logic [MODE_W-1:0] MODE_LIGHT_D = 3'd6;
	localparam logic [MODE_W-1:0] MODE_LAST    = 3'd6;

	localparam logic [SAMPLE_W-1:0] BUTTON_THR_RST = 12'd500;
	localparam logic [SCALED_W-1:0] LEVEL_LOW_RST  = 16'd11000;
	localparam logic [SCALED_W-1:0] LEVEL_HIGH_RST = 16'd22000;

	localparam logic [CH_W-1:0] CH_A = 2'd0;
	localparam logic [CH_W-1:0] CH_B = 2'd1;
	localparam logic [CH_W-1:0] CH_C = 2'd2;
	localparam logic [CH_W-1:0] CH_D = 2'd3;

	typedef enum logic [1:0] {
		REG_BUTTON_THR = 2'd0,
		REG_LEVEL_LOW  = 2'd1,
		REG_LEVEL_HIGH = 2'd2
	} reg_idx_t;

	typedef enum logic [LEVEL_W-1:0] {
		LVL_BRIGHT = 2'd0,
		LVL_DUSK   = 2'd1,
		LVL_DARK   = 2'd2,
		LVL_NONE   = 2'd3
	} light_t;

	typedef struct packed {
		logic [MODE_W-1:0] old_mode;
		logic [MODE_W-1:0] new_mode;
		logic              advanced;
	} ctrl_t;

	function automatic logic [CH_W-1:0] chan_of_mode(input logic [MODE_W-1:0] m);
		logic [CH_W-1:0] ch;
		unique case (m)
			MODE_CH_B:    ch = CH_B;
			MODE_CH_C:    ch = CH_C;
			MODE_CH_D:    ch = CH_D;
			MODE_LIGHT_C: ch = CH_C;
			MODE_LIGHT_D: ch = CH_D;
			default:      ch = CH_A;
		endcase
		return ch;
	endfunction

	function automatic logic is_light_mode(input logic [MODE_W-1:0] m);
		return (m == MODE_LIGHT_C) || (m == MODE_LIGHT_D);
	endfunction

endpackage

`default_nettype wire

// ===== design/sfe_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sfe_in_if
	import sfe_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] channel_a_sample;
	logic [SAMPLE_W-1:0] channel_b_sample;
	logic [SAMPLE_W-1:0] channel_c_sample;
	logic [SAMPLE_W-1:0] channel_d_sample;
	logic [SAMPLE_W-1:0] button_sample;

	modport source (
		output valid, channel_a_sample, channel_b_sample, channel_c_sample,
		       channel_d_sample, button_sample,
		input  ready
	);
	modport sink (
		input  valid, channel_a_sample, channel_b_sample, channel_c_sample,
		       channel_d_sample, button_sample,
		output ready
	);
endinterface

interface sfe_out_if
	import sfe_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] selected_average;
	logic [SCALED_W-1:0] scaled_value;
	logic [MODE_W-1:0]   active_mode;
	logic [LEVEL_W-1:0]  light_level;
	logic [DUTY_W-1:0]   pwm_duty;
	logic                mode_advanced;

	modport source (
		output valid, selected_average, scaled_value, active_mode, light_level,
		       pwm_duty, mode_advanced,
		input  ready
	);
	modport sink (
		input  valid, selected_average, scaled_value, active_mode, light_level,
		       pwm_duty, mode_advanced,
		output ready
	);
endinterface

`default_nettype wire

// ===== design/sfe_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfe_lane
	import sfe_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
	localparam int WI_W  = $clog2(WINDOW_DEPTH),
	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire logic [WI_W-1:0]     wr_idx,
	input  wire logic [SAMPLE_W-1:0] sample,
	output      logic [SUM_W-1:0]    sum
);

	localparam logic [SUM_W-1:0] SUM_RST = SUM_W'(WINDOW_DEPTH * int'(WINDOW_RESET));

	logic [SAMPLE_W-1:0] win_q [WINDOW_DEPTH];
	logic [SUM_W-1:0]    sum_q;

	// running sum: add the new sample, drop the one it overwrites
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				win_q[i] <= WINDOW_RESET;
			end
			sum_q <= SUM_RST;
		end else if (push) begin
			win_q[wr_idx] <= sample;
			sum_q <= sum_q + SUM_W'(sample) - SUM_W'(win_q[wr_idx]);
		end
	end

	assign sum = sum_q;

endmodule

`default_nettype wire

// ===== design/sfe_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfe_ctrl
	import sfe_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
	localparam int WI_W = $clog2(WINDOW_DEPTH)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire logic [SAMPLE_W-1:0] button,
	input  wire logic [SAMPLE_W-1:0] threshold,
	output      logic [WI_W-1:0]     wr_idx,
	output      ctrl_t               info
);

	logic [WI_W-1:0]   wi_q;
	logic [MODE_W-1:0] mode_q;
	logic              armed_q;
	logic              pend_q;
	logic              armed_d;
	logic              pend_d;
	logic [MODE_W-1:0] mode_d;

	always_comb begin
		armed_d = armed_q | (button > threshold);
		pend_d  = (pend_q | (button < threshold)) & armed_d;
		mode_d  = mode_q;
		if (pend_d) begin
			if (mode_q >= MODE_FIRST && mode_q < MODE_LAST) begin
				mode_d = mode_q + MODE_W'(1);
			end else begin
				mode_d = MODE_FIRST;
			end
		end
		info.old_mode = mode_q;
		info.new_mode = mode_d;
		info.advanced = pend_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q    <= '0;
			mode_q  <= MODE_FIRST;
			armed_q <= 1'b1;
			pend_q  <= 1'b0;
		end else if (accept) begin
			wi_q    <= (wi_q == WI_W'(WINDOW_DEPTH - 1)) ? '0 : wi_q + WI_W'(1);
			mode_q  <= mode_d;
			armed_q <= armed_d & ~pend_d;
			pend_q  <= 1'b0;
		end
	end

	assign wr_idx = wi_q;

endmodule

`default_nettype wire

// ===== design/sfe_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfe_merge
	import sfe_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s1_valid,
	output      logic                s1_ready,
	input  wire logic [SUM_W-1:0]    sums [CHANNELS],
	input  wire ctrl_t               ctrl_s1,
	input  wire logic [SCALED_W-1:0] level_low,
	input  wire logic [SCALED_W-1:0] level_high,
	sfe_out_if.source                result
);

	// divide by the window depth as a reciprocal multiply, exact for every SUM_W-bit sum
	localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW_DEPTH);
	localparam int RECIP_W   = SUM_W + 1;
	localparam int PROD_W    = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));
	localparam int SPROD_W = SAMPLE_W + SCALE_MUL_W;

	logic                v2_q, v3_q, v4_q;
	logic                rdy3, rdy4;
	logic [SUM_W-1:0]    sel_sum;
	logic [PROD_W-1:0]   div_prod;
	logic [SPROD_W-1:0]  scale_prod;
	logic [SAMPLE_W-1:0] avg_s2, avg_s3, avg_s4;
	logic [SCALED_W-1:0] scaled_s3, scaled_s4;
	ctrl_t               ctrl_s2, ctrl_s3, ctrl_s4;
	light_t              level_d, level_s4;
	logic [DUTY_W-1:0]   duty_d, duty_s4;

	assign rdy4     = ~v4_q | result.ready;
	assign rdy3     = ~v3_q | rdy4;
	assign s1_ready = ~v2_q | rdy3;

	assign sel_sum    = sums[chan_of_mode(ctrl_s1.old_mode)];
	assign div_prod   = PROD_W'(sel_sum) * PROD_W'(RECIP);
	assign scale_prod = SPROD_W'(avg_s2) * SPROD_W'(SCALE_MUL);

	always_comb begin
		if (!is_light_mode(ctrl_s3.old_mode)) begin
			level_d = LVL_NONE;
			duty_d  = PWM_OFF;
		end else if (scaled_s3 < level_low) begin
			level_d = LVL_BRIGHT;
			duty_d  = PWM_BRIGHT;
		end else if (scaled_s3 < level_high) begin
			level_d = LVL_DUSK;
			duty_d  = PWM_DUSK;
		end else begin
			level_d = LVL_DARK;
			duty_d  = PWM_DARK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				v2_q <= s1_valid;
			end
			if (rdy3) begin
				v3_q <= v2_q;
			end
			if (rdy4) begin
				v4_q <= v3_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready) begin
			avg_s2  <= SAMPLE_W'(div_prod >> DIV_SHIFT);
			ctrl_s2 <= ctrl_s1;
		end
		if (rdy3) begin
			avg_s3    <= avg_s2;
			scaled_s3 <= scale_prod[SCALE_SHIFT +: SCALED_W];
			ctrl_s3   <= ctrl_s2;
		end
		if (rdy4) begin
			avg_s4    <= avg_s3;
			scaled_s4 <= scaled_s3;
			ctrl_s4   <= ctrl_s3;
			level_s4  <= level_d;
			duty_s4   <= duty_d;
		end
	end

	assign result.valid            = v4_q;
	assign result.selected_average = avg_s4;
	assign result.scaled_value     = scaled_s4;
	assign result.active_mode      = ctrl_s4.new_mode;
	assign result.light_level      = level_s4;
	assign result.pwm_duty         = duty_s4;
	assign result.mode_advanced    = ctrl_s4.advanced;

endmodule

`default_nettype wire

// ===== design/four_channel_sensor_frontend.sv =====
// An accepted frame word passes the registers of stage 1, s2, s3 and s4; s4 drives the result word.
// Throughput: one frame word per cycle while result.ready does not stall; per-stage valid/ready lets bubbles collapse.
// Lanes keep running window sums, so a frame costs one add/subtract per channel.
// Reset (arst_n, async low): windows to 2048, mode 1, button armed, registers to
// 500 / 11000 / 22000, pipeline empty. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module four_channel_sensor_frontend
	import sfe_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	sfe_in_if.sink                     frame,
	sfe_out_if.source                  result,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output      logic [APB_DATA_W-1:0] prdata,
	output      logic                  pready
);

	localparam int WI_W  = $clog2(WINDOW_DEPTH);
	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);

	logic [SAMPLE_W-1:0] thr_q;
	logic [SCALED_W-1:0] low_q;
	logic [SCALED_W-1:0] high_q;
	reg_idx_t            reg_idx;
	logic                wr_en;

	logic                accept;
	logic                v1_q;
	logic                s1_ready;
	logic [WI_W-1:0]     wr_idx;
	ctrl_t               ctrl_d;
	ctrl_t               ctrl_s1;
	logic [SAMPLE_W-1:0] samples [CHANNELS];
	logic [SUM_W-1:0]    sums [CHANNELS];

	// config registers
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= BUTTON_THR_RST;
			low_q  <= LEVEL_LOW_RST;
			high_q <= LEVEL_HIGH_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_BUTTON_THR: thr_q  <= pwdata[SAMPLE_W-1:0];
				REG_LEVEL_LOW:  low_q  <= pwdata[SCALED_W-1:0];
				REG_LEVEL_HIGH: high_q <= pwdata[SCALED_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_BUTTON_THR: prdata = APB_DATA_W'(thr_q);
			REG_LEVEL_LOW:  prdata = APB_DATA_W'(low_q);
			REG_LEVEL_HIGH: prdata = APB_DATA_W'(high_q);
			default:        prdata = '0;
		endcase
	end

	// stage 1: lanes and mode logic take the word
	assign frame.ready = ~v1_q | s1_ready;
	assign accept      = frame.valid & frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (frame.ready) begin
			v1_q <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1 <= ctrl_d;
		end
	end

	sfe_ctrl #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.button   (frame.button_sample),
		.threshold(thr_q),
		.wr_idx   (wr_idx),
		.info     (ctrl_d)
	);

	assign samples[0] = frame.channel_a_sample;
	assign samples[1] = frame.channel_b_sample;
	assign samples[2] = frame.channel_c_sample;
	assign samples[3] = frame.channel_d_sample;

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		sfe_lane #(
			.WINDOW_DEPTH(WINDOW_DEPTH)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.push  (accept),
			.wr_idx(wr_idx),
			.sample(samples[c]),
			.sum   (sums[c])
		);
	end

	sfe_merge #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (v1_q),
		.s1_ready  (s1_ready),
		.sums      (sums),
		.ctrl_s1   (ctrl_s1),
		.level_low (low_q),
		.level_high(high_q),
		.result    (result)
	);

endmodule

`default_nettype wire

// ===== design/sfe_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfe_checker
	import sfe_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [SAMPLE_W-1:0] out_avg,
	input wire logic [MODE_W-1:0]   out_mode,
	input wire logic [LEVEL_W-1:0]  out_level,
	input wire logic [DUTY_W-1:0]   out_duty,
	input wire logic                out_adv
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_avg) && $stable(out_mode)
			&& $stable(out_level) && $stable(out_duty) && $stable(out_adv))
		else $error("result word changed while stalled");

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_mode >= MODE_FIRST && out_mode <= MODE_LAST)
		else $error("active mode out of range");

	a_duty_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_level == LVL_BRIGHT && out_duty == PWM_BRIGHT)
			|| (out_level == LVL_DUSK && out_duty == PWM_DUSK)
			|| (out_level == LVL_DARK && out_duty == PWM_DARK)
			|| (out_level == LVL_NONE && out_duty == PWM_OFF))
		else $error("pwm duty does not match light level");

	// without an advance the mode is the one that chose the light outputs
	a_light_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_adv && out_level != LVL_NONE
			|-> out_mode == MODE_LIGHT_C || out_mode == MODE_LIGHT_D)
		else $error("light level reported outside a light mode");

endmodule

bind four_channel_sensor_frontend sfe_checker u_sfe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_avg  (result.selected_average),
	.out_mode (result.active_mode),
	.out_level(result.light_level),
	.out_duty (result.pwm_duty),
	.out_adv  (result.mode_advanced)
);

`default_nettype wire

// ===== tb/sv/sfe_frontend_checker.sv =====
`timescale 1ns / 1ps

module sfe_frontend_checker
	import sfe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	sfe_in_if                     frame,
	sfe_out_if                    result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic [APB_DATA_W-1:0] prdata,
	output int                    errors,
	output int                    outstanding,
	output int                    checked,
	output int                    advances
);

	localparam int PRINT_CAP = 30;

	typedef struct packed {
		logic [SAMPLE_W-1:0] average;
		logic [SCALED_W-1:0] scaled;
		logic [MODE_W-1:0]   mode;
		light_t              level;
		logic [DUTY_W-1:0]   duty;
		logic                advanced;
	} frontend_word_t;

	logic [SAMPLE_W-1:0] window [CHANNELS][WINDOW_DEPTH_DEF];
	int unsigned         slot;
	logic                armed;
	logic                pending;
	logic [MODE_W-1:0]   mode;
	logic [SAMPLE_W-1:0] button_thr;
	logic [SCALED_W-1:0] level_low;
	logic [SCALED_W-1:0] level_high;
	frontend_word_t      expected_words [$];

	initial begin
		errors = 0;
		outstanding = 0;
		checked = 0;
		advances = 0;
	end

	task automatic report_mismatch(input string what);
		if (errors < PRINT_CAP)
			$display("[%0t] MISMATCH: %s", $realtime, what);
		errors++;
	endtask

	// pushes one frame into the windows and returns the word it should produce
	function automatic frontend_word_t frontend_response(
		input logic [SAMPLE_W-1:0] a,
		input logic [SAMPLE_W-1:0] b,
		input logic [SAMPLE_W-1:0] c,
		input logic [SAMPLE_W-1:0] d,
		input logic [SAMPLE_W-1:0] button
	);
		frontend_word_t    w;
		int unsigned       sum;
		int unsigned       avg;
		int unsigned       scaled;
		int                pick;
		int                i;
		logic [MODE_W-1:0] prior;

		prior = mode;
		window[CH_A][slot] = a;
		window[CH_B][slot] = b;
		window[CH_C][slot] = c;
		window[CH_D][slot] = d;
		slot = (slot + 1) % WINDOW_DEPTH_DEF;

		case (prior)
			MODE_CH_B:    pick = CH_B;
			MODE_CH_C:    pick = CH_C;
			MODE_CH_D:    pick = CH_D;
			MODE_LIGHT_C: pick = CH_C;
			MODE_LIGHT_D: pick = CH_D;
			default:      pick = CH_A;
		endcase
		sum = 0;
		for (i = 0; i < WINDOW_DEPTH_DEF; i++)
			sum += window[pick][i];
		avg = sum / WINDOW_DEPTH_DEF;
		scaled = (avg * SCALE_MUL) >> SCALE_SHIFT;
		w.average = avg[SAMPLE_W-1:0];
		w.scaled = scaled[SCALED_W-1:0];

		// light outputs follow the mode in force before this frame's press
		if (prior != MODE_LIGHT_C && prior != MODE_LIGHT_D) begin
			w.level = LVL_NONE;
			w.duty = PWM_OFF;
		end else if (w.scaled < level_low) begin
			w.level = LVL_BRIGHT;
			w.duty = PWM_BRIGHT;
		end else if (w.scaled < level_high) begin
			w.level = LVL_DUSK;
			w.duty = PWM_DUSK;
		end else begin
			w.level = LVL_DARK;
			w.duty = PWM_DARK;
		end

		// equal to threshold: neither press nor re-arm
		if (button > button_thr)
			armed = 1'b1;
		pending = (pending | (button < button_thr)) & armed;
		w.advanced = 1'b0;
		if (pending && armed) begin
			mode = (mode >= MODE_FIRST && mode < MODE_LAST) ? mode + 1'b1 : MODE_FIRST;
			pending = 1'b0;
			armed = 1'b0;
			w.advanced = 1'b1;
		end
		w.mode = mode;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frontend_word_t got;
		frontend_word_t want;
		logic [APB_DATA_W-1:0] reg_value;
		logic mapped;

		if (!arst_n) begin
			for (int ch = 0; ch < CHANNELS; ch++)
				for (int k = 0; k < WINDOW_DEPTH_DEF; k++)
					window[ch][k] = WINDOW_RESET;
			slot = 0;
			armed = 1'b1;
			pending = 1'b0;
			mode = MODE_FIRST;
			button_thr = BUTTON_THR_RST;
			level_low = LEVEL_LOW_RST;
			level_high = LEVEL_HIGH_RST;
			expected_words.delete();
			outstanding <= 0;
		end else begin
			if (psel && penable && pready) begin
				mapped = 1'b1;
				if (pwrite) begin
					case (paddr[APB_ADDR_W-1:2])
						REG_BUTTON_THR: button_thr = pwdata[SAMPLE_W-1:0];
						REG_LEVEL_LOW:  level_low = pwdata[SCALED_W-1:0];
						REG_LEVEL_HIGH: level_high = pwdata[SCALED_W-1:0];
						default:        mapped = 1'b0;
					endcase
				end else begin
					case (paddr[APB_ADDR_W-1:2])
						REG_BUTTON_THR: reg_value = APB_DATA_W'(button_thr);
						REG_LEVEL_LOW:  reg_value = APB_DATA_W'(level_low);
						REG_LEVEL_HIGH: reg_value = APB_DATA_W'(level_high);
						default:        mapped = 1'b0;
					endcase
					if (mapped && prdata !== reg_value)
						report_mismatch($sformatf("register read at 0x%0h got 0x%0h want 0x%0h",
							paddr, prdata, reg_value));
				end
			end

			if (frame.valid && frame.ready)
				expected_words.push_back(frontend_response(frame.channel_a_sample,
					frame.channel_b_sample, frame.channel_c_sample,
					frame.channel_d_sample, frame.button_sample));

			if (result.valid && result.ready) begin
				got.average = result.selected_average;
				got.scaled = result.scaled_value;
				got.mode = result.active_mode;
				got.level = light_t'(result.light_level);
				got.duty = result.pwm_duty;
				got.advanced = result.mode_advanced;
				if (expected_words.size() == 0) begin
					report_mismatch("result word with no frame outstanding");
				end else begin
					want = expected_words.pop_front();
					checked <= checked + 1;
					if (want.advanced)
						advances <= advances + 1;
					if (got.average !== want.average)
						report_mismatch($sformatf("selected_average got %0d want %0d",
							got.average, want.average));
					if (got.scaled !== want.scaled)
						report_mismatch($sformatf("scaled_value got %0d want %0d",
							got.scaled, want.scaled));
					if (got.mode !== want.mode)
						report_mismatch($sformatf("active_mode got %0d want %0d",
							got.mode, want.mode));
					if (got.level !== want.level)
						report_mismatch($sformatf("light_level got %0d want %0d",
							got.level, want.level));
					if (got.duty !== want.duty)
						report_mismatch($sformatf("pwm_duty got %0d want %0d",
							got.duty, want.duty));
					if (got.advanced !== want.advanced)
						report_mismatch($sformatf("mode_advanced got %0b want %0b",
							got.advanced, want.advanced));
				end
			end
			outstanding <= expected_words.size();
		end
	end

endmodule

// ===== tb/sv/tb_four_channel_sensor_frontend.sv =====
`timescale 1ns / 1ps

module tb_four_channel_sensor_frontend;
	import sfe_pkg::*;

	localparam logic [1:0] REG_UNMAPPED = 2'd3;
	localparam int FRAME_LATENCY = 4;
	localparam int SETTLE_CYCLES = 2 * FRAME_LATENCY;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'd4095;
	localparam logic [SCALED_W-1:0] SCALED_MAX = 16'd32991;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  calm = 1'b0;
	logic [SAMPLE_W-1:0]   cur_thr = BUTTON_THR_RST;
	logic [SAMPLE_W-1:0]   base_level = WINDOW_RESET;
	int                    settings = 1;
	int                    errors;
	int                    outstanding;
	int                    checked;
	int                    advances;

	sfe_in_if  frame ();
	sfe_out_if result ();

	always #2 clk = ~clk;

	four_channel_sensor_frontend DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.frame   (frame),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	sfe_frontend_checker frontend_watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame       (frame),
		.result      (result),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked),
		.advances    (advances)
	);

	// all tasks below start and end on a falling edge
	task automatic apb_access(input logic write, input logic [1:0] idx,
		input logic [APB_DATA_W-1:0] data);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = write;
		paddr = {idx, 2'b00};
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic apply_setting(input logic [SAMPLE_W-1:0] thr,
		input logic [SCALED_W-1:0] lo, input logic [SCALED_W-1:0] hi);
		frame.valid = 1'b0;
		wait (outstanding == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		// junk in the unused upper bits must be dropped
		apb_access(1'b1, REG_BUTTON_THR, ($urandom() & 32'hFFFF_F000) | APB_DATA_W'(thr));
		apb_access(1'b1, REG_LEVEL_LOW, ($urandom() & 32'hFFFF_0000) | APB_DATA_W'(lo));
		apb_access(1'b1, REG_LEVEL_HIGH, ($urandom() & 32'hFFFF_0000) | APB_DATA_W'(hi));
		apb_access(1'b1, REG_UNMAPPED, $urandom());
		apb_access(1'b0, REG_BUTTON_THR, '0);
		apb_access(1'b0, REG_LEVEL_LOW, '0);
		apb_access(1'b0, REG_LEVEL_HIGH, '0);
		cur_thr = thr;
		settings++;
	endtask

	task automatic push_frame(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b,
		input logic [SAMPLE_W-1:0] c, input logic [SAMPLE_W-1:0] d,
		input logic [SAMPLE_W-1:0] button);
		if (!calm && $urandom_range(0, 3) == 0) begin
			frame.valid = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		frame.valid = 1'b1;
		frame.channel_a_sample = a;
		frame.channel_b_sample = b;
		frame.channel_c_sample = c;
		frame.channel_d_sample = d;
		frame.button_sample = button;
		do @(posedge clk); while (!frame.ready);
		@(negedge clk);
	endtask

	// mostly near a slowly wandering level so averages reach every light band
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int v;
		case ($urandom_range(0, 7))
			0:       v = 0;
			1:       v = SAMPLE_MAX;
			2, 3:    v = $urandom_range(0, SAMPLE_MAX);
			default: v = int'(base_level) + $urandom_range(0, 200) - 100;
		endcase
		if (v < 0)
			v = 0;
		if (v > SAMPLE_MAX)
			v = SAMPLE_MAX;
		return v[SAMPLE_W-1:0];
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_button();
		int v;
		case ($urandom_range(0, 9))
			0:       v = 0;
			1:       v = SAMPLE_MAX;
			2:       v = int'(cur_thr) - 1;
			3:       v = cur_thr;
			4:       v = int'(cur_thr) + 1;
			5, 6:    v = $urandom_range(0, cur_thr);
			7, 8:    v = $urandom_range(cur_thr, SAMPLE_MAX);
			default: v = $urandom_range(0, SAMPLE_MAX);
		endcase
		if (v < 0)
			v = 0;
		if (v > SAMPLE_MAX)
			v = SAMPLE_MAX;
		return v[SAMPLE_W-1:0];
	endfunction

	task automatic push_random_frames(input int count);
		repeat (count) begin
			if ($urandom_range(0, 19) == 0) begin
				case ($urandom_range(0, 2))
					0:       base_level = '0;
					1:       base_level = SAMPLE_MAX;
					default: base_level = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
				endcase
			end
			push_frame(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
				pick_button());
		end
	endtask

	// sink side: stall bursts between runs of ready
	initial begin
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 2) == 0) begin
				result.ready = 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end
			result.ready = 1'b1;
			repeat ($urandom_range(0, 30)) @(negedge clk);
		end
	end

	initial begin
		frame.valid = 1'b0;
		frame.channel_a_sample = '0;
		frame.channel_b_sample = '0;
		frame.channel_c_sample = '0;
		frame.channel_d_sample = '0;
		frame.button_sample = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed walk through all six modes at reset register values
		push_frame(12'd0, 12'd0, 12'd0, 12'd0, 12'd2048);
		push_frame(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
		push_frame(SAMPLE_MAX, 12'd0, SAMPLE_MAX, 12'd0, 12'd500);
		push_frame(12'd1234, 12'd2345, 12'd3456, 12'd4000, 12'd0);
		push_frame(12'd1, 12'd4094, 12'd2047, 12'd2049, 12'd0);
		push_frame(12'd100, 12'd200, 12'd300, 12'd400, 12'd500);
		push_frame(12'd2730, 12'd1365, 12'd3276, 12'd819, 12'd501);
		push_frame(12'd4095, 12'd4095, 12'd0, 12'd0, 12'd499);
		push_frame(12'd0, 12'd0, 12'd4095, 12'd4095, SAMPLE_MAX);
		push_frame(12'd5, 12'd6, 12'd7, 12'd8, 12'd0);
		push_frame(12'd3000, 12'd3000, 12'd3000, 12'd3000, SAMPLE_MAX);
		push_frame(12'd3000, 12'd3000, 12'd3000, 12'd3000, 12'd0);
		push_frame(12'd0, 12'd0, 12'd0, 12'd0, SAMPLE_MAX);
		push_frame(12'd0, 12'd0, 12'd0, 12'd0, 12'd2000);
		push_frame(12'd0, 12'd0, 12'd0, 12'd0, 12'd2000);
		push_frame(12'd0, 12'd0, 12'd0, 12'd0, 12'd2000);
		push_frame(12'd0, 12'd0, SAMPLE_MAX, 12'd0, 12'd2000);
		push_frame(12'd0, 12'd0, SAMPLE_MAX, 12'd0, 12'd2000);
		push_frame(12'd0, 12'd0, SAMPLE_MAX, 12'd0, 12'd2000);
		push_frame(12'd0, 12'd0, SAMPLE_MAX, 12'd0, 12'd0);
		push_frame(12'd0, 12'd0, 12'd0, 12'd0, SAMPLE_MAX);
		push_frame(12'd0, 12'd0, 12'd0, 12'd0, 12'd0);

		push_random_frames(150);
		apply_setting('0, '0, '0);
		push_random_frames(80);
		apply_setting(SAMPLE_MAX, SCALED_MAX, SCALED_MAX);
		push_random_frames(80);
		// low limit above high limit: nothing is dusk
		apply_setting(12'd2048, 16'd20000, 16'd8000);
		push_random_frames(120);
		repeat (3) begin
			apply_setting(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)),
				SCALED_W'($urandom_range(0, SCALED_MAX)),
				SCALED_W'($urandom_range(0, SCALED_MAX)));
			push_random_frames(50);
		end
		apply_setting(12'd1, 16'd16500, 16'd16501);
		push_random_frames(20);
		calm = 1'b1;
		push_random_frames(100);

		frame.valid = 1'b0;
		wait (outstanding == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d frame words over %0d register settings, %0d mode advances",
			checked, settings, advances);
		$display("source gaps and sink stalls in bursts, idle-free tail at the end");
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d words outstanding", outstanding);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== files.f =====
design/sfe_pkg.sv
design/sfe_if.sv
design/sfe_lane.sv
design/sfe_ctrl.sv
design/sfe_merge.sv
design/four_channel_sensor_frontend.sv
design/sfe_checker.sv
tb/sv/sfe_frontend_checker.sv
tb/sv/tb_four_channel_sensor_frontend.sv
